// ----- hw/rtl/itp_pkg.sv -----
// ----------------------------------------------------------------------------
// itp_pkg: shared types and constants of the infix to postfix converter
// Token kinds, result codes, request payload structs and the
// controller-to-datapath command and status structs.
// ----------------------------------------------------------------------------
package itp_pkg;

    localparam int STACK_DEPTH_DEF = 16;

    // token kinds
    localparam logic [3:0] K_NUMBER = 4'd0;
    localparam logic [3:0] K_SPACE  = 4'd1;
    localparam logic [3:0] K_LSQ    = 4'd2;
    localparam logic [3:0] K_RSQ    = 4'd3;
    localparam logic [3:0] K_LPAR   = 4'd4;
    localparam logic [3:0] K_RPAR   = 4'd5;
    localparam logic [3:0] K_LCUR   = 4'd6;
    localparam logic [3:0] K_RCUR   = 4'd7;
    localparam logic [3:0] K_ADD    = 4'd8;
    localparam logic [3:0] K_SUB    = 4'd9;
    localparam logic [3:0] K_MUL    = 4'd10;
    localparam logic [3:0] K_DIV    = 4'd11;
    localparam logic [3:0] K_END    = 4'd12;

    // result types
    localparam logic [1:0] OT_NUMBER   = 2'd0;
    localparam logic [1:0] OT_OPERATOR = 2'd1;
    localparam logic [1:0] OT_ERROR    = 2'd2;
    localparam logic [1:0] OT_DONE     = 2'd3;

    // error codes
    localparam logic [1:0] ERR_NONE     = 2'd0;
    localparam logic [1:0] ERR_MISMATCH = 2'd1;
    localparam logic [1:0] ERR_OVERFLOW = 2'd2;

    typedef struct packed {
        logic [3:0]  kind;
        logic [63:0] number_value;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  out_type;
        logic [1:0]  op_code;
        logic [63:0] out_value;
        logic [1:0]  error_code;
        logic        last;
    } t_out_item;

    typedef struct packed {
        logic       load;      // capture the incoming request
        logic       emit;      // stage a new result
        logic       finish;    // flush the staged result marked last
        logic       push;
        logic       pop;
        logic       clear;
        logic [1:0] res_type;
        logic [1:0] err_code;
    } t_cmd;

    typedef struct packed {
        logic [3:0] kind;
        logic [3:0] top;
        logic       empty;
        logic       full;
        logic       stage_ok;  // a result may be staged or flushed this cycle
    } t_stat;

    function automatic logic is_opener(input logic [3:0] k);
        return (k == K_LSQ) || (k == K_LPAR) || (k == K_LCUR);
    endfunction

    function automatic logic [1:0] prec_of(input logic [3:0] k);
        logic [1:0] p;
        p = 2'd0;
        if ((k == K_ADD) || (k == K_SUB)) p = 2'd1;
        if ((k == K_MUL) || (k == K_DIV)) p = 2'd2;
        return p;
    endfunction

endpackage

// ----- hw/rtl/itp_dpath.sv -----
// ----------------------------------------------------------------------------
// itp_dpath: converter datapath
// Token register, operator stack memory, stack count, one-deep result
// staging register and output register.
// ----------------------------------------------------------------------------
module itp_dpath #(
    parameter int STACK_DEPTH = itp_pkg::STACK_DEPTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  itp_pkg::t_in_item   i_in_data,
    input  itp_pkg::t_cmd       i_cmd,
    output itp_pkg::t_stat      o_stat,
    output logic                o_valid,
    input  logic                i_ready,
    output itp_pkg::t_out_item  o_out_data
);
    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int IW = $clog2(STACK_DEPTH);

    logic [3:0]         r_kind;
    logic [63:0]        r_value;
    logic [3:0]         r_stack [STACK_DEPTH];
    logic [3:0]         r_top;
    logic [CW-1:0]      r_count;
    logic [CW-1:0]      n_count;
    logic [CW-1:0]      top_pos;
    logic               r_pend_valid;
    itp_pkg::t_out_item r_pend;
    itp_pkg::t_out_item new_res;
    itp_pkg::t_out_item flush_res;
    logic               r_out_valid;
    itp_pkg::t_out_item r_out;
    logic               load_out;

    assign top_pos = r_count - CW'(1);

    // token capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind  <= i_in_data.kind;
            r_value <= i_in_data.number_value;
        end
    end

    // stack memory, registered read of the top entry
    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_stack[r_count[IW-1:0]] <= r_kind;
        end
        r_top <= r_stack[top_pos[IW-1:0]];
    end

    always_comb begin
        n_count = r_count;
        if (i_cmd.clear) begin
            n_count = '0;
        end else if (i_cmd.push) begin
            n_count = r_count + CW'(1);
        end else if (i_cmd.pop) begin
            n_count = top_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    // result built from command and stack top
    always_comb begin
        new_res            = '0;
        new_res.out_type   = i_cmd.res_type;
        new_res.error_code = i_cmd.err_code;
        if (i_cmd.res_type == itp_pkg::OT_OPERATOR) begin
            new_res.op_code = r_top[1:0];
        end
        if (i_cmd.res_type == itp_pkg::OT_NUMBER) begin
            new_res.out_value = r_value;
        end
    end

    // staged result moving to the output, marked last on the final flush
    always_comb begin
        flush_res      = r_pend;
        flush_res.last = i_cmd.finish;
    end

    assign load_out = (i_cmd.emit || i_cmd.finish) && r_pend_valid;

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_pend <= new_res;
        end
        if (load_out) begin
            r_out <= flush_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cmd.emit) begin
                r_pend_valid <= 1'b1;
            end else if (i_cmd.finish) begin
                r_pend_valid <= 1'b0;
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_stat.kind     = r_kind;
    assign o_stat.top      = r_top;
    assign o_stat.empty    = (r_count == '0);
    assign o_stat.full     = (r_count == CW'(STACK_DEPTH));
    assign o_stat.stage_ok = !r_pend_valid || !r_out_valid || i_ready;

    assign o_valid    = r_out_valid;
    assign o_out_data = r_out;

endmodule

// ----- hw/rtl/itp_ctrl.sv -----
// ----------------------------------------------------------------------------
// itp_ctrl: converter controller
// Sequences one token at a time: decode, read stack top, evaluate, push,
// and flush of the final result.
// ----------------------------------------------------------------------------
module itp_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  itp_pkg::t_stat i_stat,
    output itp_pkg::t_cmd  o_cmd
);
    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_DECODE = 6'b000010,
        ST_READ   = 6'b000100,
        ST_EVAL   = 6'b001000,
        ST_PUSH   = 6'b010000,
        ST_FINISH = 6'b100000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   closer_match;
    logic   top_opener;

    assign closer_match = (i_stat.top == (i_stat.kind - 4'd1));
    assign top_opener   = itp_pkg::is_opener(i_stat.top);

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_DECODE;
                end
            end
            ST_DECODE: begin
                case (i_stat.kind) inside
                    itp_pkg::K_NUMBER: begin
                        if (i_stat.stage_ok) begin
                            o_cmd.emit     = 1'b1;
                            o_cmd.res_type = itp_pkg::OT_NUMBER;
                            n_state        = ST_FINISH;
                        end
                    end
                    itp_pkg::K_LSQ, itp_pkg::K_LPAR, itp_pkg::K_LCUR: begin
                        n_state = ST_PUSH;
                    end
                    itp_pkg::K_RSQ, itp_pkg::K_RPAR, itp_pkg::K_RCUR: begin
                        if (!i_stat.empty) begin
                            n_state = ST_READ;
                        end else if (i_stat.stage_ok) begin
                            o_cmd.emit     = 1'b1;
                            o_cmd.res_type = itp_pkg::OT_ERROR;
                            o_cmd.err_code = itp_pkg::ERR_MISMATCH;
                            o_cmd.clear    = 1'b1;
                            n_state        = ST_FINISH;
                        end
                    end
                    [itp_pkg::K_ADD:itp_pkg::K_DIV]: begin
                        n_state = i_stat.empty ? ST_PUSH : ST_READ;
                    end
                    itp_pkg::K_END: begin
                        if (!i_stat.empty) begin
                            n_state = ST_READ;
                        end else if (i_stat.stage_ok) begin
                            o_cmd.emit     = 1'b1;
                            o_cmd.res_type = itp_pkg::OT_DONE;
                            n_state        = ST_FINISH;
                        end
                    end
                    default: begin
                        // space and unknown kinds: drop
                        n_state = ST_IDLE;
                    end
                endcase
            end
            ST_READ: begin
                n_state = ST_EVAL;
            end
            ST_EVAL: begin
                if (i_stat.kind == itp_pkg::K_END) begin
                    if (i_stat.stage_ok) begin
                        o_cmd.emit = 1'b1;
                        if (top_opener) begin
                            o_cmd.res_type = itp_pkg::OT_ERROR;
                            o_cmd.err_code = itp_pkg::ERR_MISMATCH;
                            o_cmd.clear    = 1'b1;
                            n_state        = ST_FINISH;
                        end else begin
                            o_cmd.res_type = itp_pkg::OT_OPERATOR;
                            o_cmd.pop      = 1'b1;
                            n_state        = ST_DECODE;
                        end
                    end
                end else if (i_stat.kind < itp_pkg::K_ADD) begin
                    // closing bracket
                    if (closer_match) begin
                        o_cmd.pop = 1'b1;
                        n_state   = ST_FINISH;
                    end else if (i_stat.stage_ok) begin
                        o_cmd.emit = 1'b1;
                        if (top_opener) begin
                            o_cmd.res_type = itp_pkg::OT_ERROR;
                            o_cmd.err_code = itp_pkg::ERR_MISMATCH;
                            o_cmd.clear    = 1'b1;
                            n_state        = ST_FINISH;
                        end else begin
                            o_cmd.res_type = itp_pkg::OT_OPERATOR;
                            o_cmd.pop      = 1'b1;
                            n_state        = ST_DECODE;
                        end
                    end
                end else begin
                    // arithmetic operator
                    if (top_opener ||
                        (itp_pkg::prec_of(i_stat.top) < itp_pkg::prec_of(i_stat.kind))) begin
                        n_state = ST_PUSH;
                    end else if (i_stat.stage_ok) begin
                        o_cmd.emit     = 1'b1;
                        o_cmd.res_type = itp_pkg::OT_OPERATOR;
                        o_cmd.pop      = 1'b1;
                        n_state        = ST_DECODE;
                    end
                end
            end
            ST_PUSH: begin
                if (!i_stat.full) begin
                    o_cmd.push = 1'b1;
                    n_state    = ST_FINISH;
                end else if (i_stat.stage_ok) begin
                    o_cmd.emit     = 1'b1;
                    o_cmd.res_type = itp_pkg::OT_ERROR;
                    o_cmd.err_code = itp_pkg::ERR_OVERFLOW;
                    o_cmd.clear    = 1'b1;
                    n_state        = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (i_stat.stage_ok) begin
                    o_cmd.finish = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ----- hw/rtl/infix_to_postfix_converter_top.sv -----
// ----------------------------------------------------------------------------
// infix_to_postfix_converter_top: infix to postfix token converter
// Operator-stack converter from infix token order to postfix token order.
// ----------------------------------------------------------------------------
// Tokens enter one request at a time on the input channel and leave in
// postfix order on the output channel. One token is processed at a time:
// a number goes through capture, decode and flush, whitespace through
// capture and decode, and an opening bracket through capture, decode, push
// and flush. Every look at the stack top takes decode, stack memory read
// and evaluate, since the stack memory delivers its top entry in the cycle
// after the count settles, and each operator popped costs one such look.
// An operator then pushes, after it empties the stack or stops at a lower
// operator or an opener; a closing bracket or an end goes on to the flush
// once it meets an opener or runs the stack empty. Output stalls can hold
// any of these steps. The last result of each token is marked by last; to
// know which one that is, every result is held one step in a staging
// register before it moves to the output register, so results from one
// token may reach the output while the next token is being taken.
// Brackets have precedence 0, + and - have 1, * and / have 2, all left
// associative. A mismatched bracket emits an error result and clears the
// stack, as does a push onto a full stack (STACK_DEPTH entries). No
// clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module infix_to_postfix_converter_top #(
    parameter int STACK_DEPTH = itp_pkg::STACK_DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  itp_pkg::t_in_item  i_in_data,
    output logic               o_valid,
    input  logic               i_ready,
    output itp_pkg::t_out_item o_out_data
);
    itp_pkg::t_cmd  cmd;
    itp_pkg::t_stat stat;

    // sequence each token through decode, stack walk and result flush
    itp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_valid),
        .o_in_ready (o_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // hold the token, the operator stack and the result registers
    itp_dpath #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_data  (i_in_data),
        .i_cmd      (cmd),
        .o_stat     (stat),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_out_data (o_out_data)
    );

endmodule
